// ----- rtl/indexed_list_with_capacity_policy_macros.svh -----
// Assertion macros for the indexed list block.
`ifndef INDEXED_LIST_WITH_CAPACITY_POLICY_MACROS_SVH
`define INDEXED_LIST_WITH_CAPACITY_POLICY_MACROS_SVH
`ifndef SYNTHESIS
`define ILCP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define ILCP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ILCP_ASSERT_IMP(lbl, ante, cons, msg)
`define ILCP_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ----- rtl/ilcp_pkg.sv -----
// Types and constants shared by the indexed list block.
package ilcp_pkg;

    localparam int WORD_W         = 32;
    localparam int POS_W          = 10;
    localparam int FIELD_W        = 11;
    localparam int CFG_IDX_W      = 3;
    localparam int TREE_RADIX_LOG = 4;
    localparam int TREE_RADIX     = 1 << TREE_RADIX_LOG;

    localparam logic [1:0] CMD_APPEND = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_READ   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_INIT_CAP = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GROW     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESH   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DIV      = 3'd3;

    localparam logic [10:0] RST_INIT_CAP = 11'd10;
    localparam logic [4:0]  RST_GROW     = 5'd2;
    localparam logic [6:0]  RST_THRESH   = 7'd4;
    localparam logic [4:0]  RST_DIV      = 5'd2;

    typedef struct packed {
        logic [1:0]              command;
        logic [POS_W-1:0]        position;
        logic signed [WORD_W-1:0] word_in;
    } item_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] word_out;
        logic                     fault;
        logic [FIELD_W-1:0]       count_now;
        logic [FIELD_W-1:0]       capacity_now;
    } res_t;

    typedef struct packed {
        logic              append_en;
        logic              remove_en;
        logic              sel_en;
        logic [POS_W-1:0]  pos;
        logic [WORD_W-1:0] word;
    } arr_cmd_t;

    typedef struct packed {
        logic load;
        logic shift;
        logic sel;
    } cell_ctl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_WAIT
    } state_t;

endpackage

// ----- rtl/ilcp_cell.sv -----
// One storage cell of the word chain: load, shift down from its upper neighbor, tap out.
module ilcp_cell
    import ilcp_pkg::*;
(
    input  logic              clk,
    input  cell_ctl_t         ctl,
    input  logic [WORD_W-1:0] word_in,
    input  logic [WORD_W-1:0] upper,
    output logic [WORD_W-1:0] word,
    output logic [WORD_W-1:0] tap
);

    logic [WORD_W-1:0] word_reg;
    logic [WORD_W-1:0] word_next;

    always_comb
    begin
        word_next = word_reg;
        if (ctl.load)
        begin
            word_next = word_in;
        end
        else if (ctl.shift)
        begin
            word_next = upper;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word = word_reg;
    assign tap  = ctl.sel ? word_reg : '0;

endmodule

// ----- rtl/ilcp_or_tree.sv -----
// Registered OR reduction tree that collects the selected cell word.
module ilcp_or_tree
    import ilcp_pkg::*;
#(
    parameter int LEAVES = 1024,
    parameter int LEVELS = 3
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [WORD_W-1:0] leaf [LEAVES],
    output logic [WORD_W-1:0] root
);

    localparam int NLEAF = TREE_RADIX ** LEVELS;
    localparam int NINT  = (NLEAF - 1) / (TREE_RADIX - 1);

    logic [WORD_W-1:0] node_reg  [NINT];
    logic [WORD_W-1:0] node_next [NINT];
    logic [WORD_W-1:0] kid       [NINT][TREE_RADIX];

    genvar k, j;
    for (k = 0; k < NINT; k++)
    begin : g_node
        for (j = 0; j < TREE_RADIX; j++)
        begin : g_kid
            localparam int C = TREE_RADIX * k + 1 + j;
            if (C < NINT)
            begin : g_int
                assign kid[k][j] = node_reg[C];
            end
            else if (C - NINT < LEAVES)
            begin : g_leaf
                assign kid[k][j] = leaf[C - NINT];
            end
            else
            begin : g_pad
                assign kid[k][j] = '0;
            end
        end
    end

    always_comb
    begin
        for (int n = 0; n < NINT; n++)
        begin
            node_next[n] = '0;
            for (int m = 0; m < TREE_RADIX; m++)
            begin
                node_next[n] = node_next[n] | kid[n][m];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int n = 0; n < NINT; n++)
            begin
                node_reg[n] <= '0;
            end
        end
        else
        begin
            node_reg <= node_next;
        end
    end

    assign root = node_reg[0];

endmodule

// ----- rtl/ilcp_ctrl.sv -----
// Command sequencer, capacity policy, serial divider and configuration registers.
module ilcp_ctrl
    import ilcp_pkg::*;
#(
    parameter int DEPTH    = 1024,
    parameter int CNT_W    = 11,
    parameter int TREE_LVL = 3
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  item_t                item,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [FIELD_W-1:0]   cfg_data,
    input  logic [WORD_W-1:0]    root,
    output logic [CNT_W-1:0]     count,
    output arr_cmd_t             acmd,
    output logic                 result_valid,
    output res_t                 result
);

    localparam int CMP_W    = (CNT_W > FIELD_W) ? CNT_W : FIELD_W;
    localparam int K_RD     = TREE_LVL - 1;
    localparam int K_REM    = (K_RD > CNT_W) ? K_RD : CNT_W;
    localparam int DIV_LAST = K_REM - CNT_W;
    localparam int WT_W     = $clog2(K_REM + 1);
    localparam int GROW_W   = CNT_W + 5;
    localparam int MUL_W    = CNT_W + 7;
    localparam logic [CNT_W-1:0] RST_CAP =
        (DEPTH < int'(RST_INIT_CAP)) ? CNT_W'(DEPTH) : CNT_W'(RST_INIT_CAP);

    state_t             state_reg, state_next;
    item_t              item_reg, item_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   cap_reg, cap_next;
    logic [10:0]        init_reg, init_next;
    logic [4:0]         grow_reg, grow_next;
    logic [6:0]         thr_reg, thr_next;
    logic [4:0]         div_reg, div_next;
    logic [WT_W-1:0]    dly_reg, dly_next;
    logic [CNT_W-1:0]   quo_reg, quo_next;
    logic [4:0]         rem_reg, rem_next;
    logic [WORD_W-1:0]  hold_reg, hold_next;
    logic               shrink_reg, shrink_next;
    res_t               res_reg, res_next;
    logic               res_valid_reg, res_valid_next;

    logic               idx_ok;
    logic               append_ok;
    logic               remove_ok;
    logic               read_ok;
    logic [GROW_W-1:0]  grown;
    logic [CNT_W-1:0]   count_dec;
    logic [6:0]         thr_eff;
    logic               sparse;
    logic [5:0]         trial;
    logic               q_bit;

    assign idx_ok    = CMP_W'(item_reg.position) < CMP_W'(count_reg);
    assign append_ok = (item_reg.command == CMD_APPEND) && (count_reg != CNT_W'(DEPTH));
    assign remove_ok = (item_reg.command == CMD_REMOVE) && idx_ok;
    assign read_ok   = (item_reg.command == CMD_READ) && idx_ok;
    assign count_dec = count_reg - 1'b1;
    assign thr_eff   = (thr_reg < {2'b00, div_reg}) ? {1'b0, div_reg, 1'b0} : thr_reg;
    assign sparse    = (MUL_W'(count_dec) * MUL_W'(thr_eff)) < MUL_W'(cap_reg);
    assign trial     = {rem_reg, quo_reg[CNT_W-1]};
    assign q_bit     = trial >= {1'b0, div_reg};

    always_comb
    begin
        grown = GROW_W'(cap_reg) * GROW_W'(grow_reg);
        if (grown == '0)
        begin
            grown = GROW_W'(1);
        end
        if (grown > GROW_W'(DEPTH))
        begin
            grown = GROW_W'(DEPTH);
        end
        if (grown <= GROW_W'(count_reg))
        begin
            grown = GROW_W'(count_reg) + 1'b1;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        count_next     = count_reg;
        cap_next       = cap_reg;
        init_next      = init_reg;
        grow_next      = grow_reg;
        thr_next       = thr_reg;
        div_next       = div_reg;
        dly_next       = dly_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        hold_next      = hold_reg;
        shrink_next    = shrink_reg;
        res_next       = res_reg;
        res_valid_next = 1'b0;
        acmd           = '0;
        acmd.pos       = item_reg.position;
        acmd.word      = item_reg.word_in;

        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_INIT_CAP:
                begin
                    init_next  = cfg_data;
                    count_next = '0;
                    cap_next   = (CMP_W'(cfg_data) > CMP_W'(DEPTH)) ?
                                 CNT_W'(DEPTH) : CNT_W'(cfg_data);
                end
                CFG_GROW:   grow_next = cfg_data[4:0];
                CFG_THRESH: thr_next  = cfg_data[6:0];
                CFG_DIV:    div_next  = cfg_data[4:0];
                default:    ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    item_next  = item;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                acmd.append_en = append_ok;
                acmd.remove_en = remove_ok;
                acmd.sel_en    = remove_ok || read_ok;
                hold_next      = '0;
                quo_next       = cap_reg;
                rem_next       = '0;
                shrink_next    = (div_reg != '0) && sparse;
                if (append_ok)
                begin
                    count_next = count_reg + 1'b1;
                    if (count_reg >= cap_reg)
                    begin
                        cap_next = CNT_W'(grown);
                    end
                end
                if (remove_ok)
                begin
                    count_next = count_dec;
                end
                if (remove_ok || read_ok)
                begin
                    dly_next   = remove_ok ? WT_W'(K_REM) : WT_W'(K_RD);
                    state_next = ST_WAIT;
                end
                else
                begin
                    res_next.word_out     = '0;
                    res_next.fault        = !append_ok;
                    res_next.count_now    = FIELD_W'(count_next);
                    res_next.capacity_now = FIELD_W'(cap_next);
                    res_valid_next        = 1'b1;
                    state_next            = ST_IDLE;
                end
            end
            ST_WAIT:
            begin
                hold_next = hold_reg | root;
                if ((item_reg.command == CMD_REMOVE) && (dly_reg > WT_W'(DIV_LAST)))
                begin
                    rem_next = q_bit ? 5'(trial - {1'b0, div_reg}) : trial[4:0];
                    quo_next = CNT_W'({quo_reg, q_bit});
                end
                if (dly_reg == '0)
                begin
                    if ((item_reg.command == CMD_REMOVE) && shrink_reg &&
                        (CMP_W'(quo_reg) >= CMP_W'(init_reg)))
                    begin
                        cap_next = quo_reg;
                    end
                    res_next.word_out     = hold_reg | root;
                    res_next.fault        = 1'b0;
                    res_next.count_now    = FIELD_W'(count_reg);
                    res_next.capacity_now = FIELD_W'(cap_next);
                    res_valid_next        = 1'b1;
                    state_next            = ST_IDLE;
                end
                else
                begin
                    dly_next = dly_reg - 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            cap_reg       <= RST_CAP;
            init_reg      <= RST_INIT_CAP;
            grow_reg      <= RST_GROW;
            thr_reg       <= RST_THRESH;
            div_reg       <= RST_DIV;
            dly_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            cap_reg       <= cap_next;
            init_reg      <= init_next;
            grow_reg      <= grow_next;
            thr_reg       <= thr_next;
            div_reg       <= div_next;
            dly_reg       <= dly_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        quo_reg    <= quo_next;
        rem_reg    <= rem_next;
        hold_reg   <= hold_next;
        shrink_reg <= shrink_next;
        res_reg    <= res_next;
    end

    assign busy         = state_reg != ST_IDLE;
    assign cfg_ready    = 1'b1;
    assign count        = count_reg;
    assign result_valid = res_valid_reg;
    assign result       = res_reg;

endmodule

// ----- rtl/indexed_list_with_capacity_policy.sv -----
// Top level of the indexed list with capacity policy: cell chain, OR tree and sequencer.
// Append and faulting commands: the result is registered straight from the execute state.
// Read: the wait state holds while the selected word passes up the registered OR tree.
// Remove: the wait state holds until the OR tree and the bit-serial capacity divider finish.
// One item at a time; the next start is taken in the cycle the result strobe is high.
// Reset sets count, capacity and config registers to defaults; stored words are not cleared.
`include "indexed_list_with_capacity_policy_macros.svh"
module indexed_list_with_capacity_policy
    import ilcp_pkg::*;
#(
    parameter int DEPTH = 1024
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  item_t                item,
    output logic                 result_valid,
    output res_t                 result,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [FIELD_W-1:0]   cfg_data
);

    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int LVL_RAW  = ($clog2(DEPTH) + TREE_RADIX_LOG - 1) / TREE_RADIX_LOG;
    localparam int TREE_LVL = (LVL_RAW < 1) ? 1 : LVL_RAW;

    logic [CNT_W-1:0]  count;
    arr_cmd_t          acmd;
    logic [WORD_W-1:0] root;
    logic [WORD_W-1:0] word [DEPTH];
    logic [WORD_W-1:0] tap  [DEPTH];
    cell_ctl_t         ctl  [DEPTH];

    genvar i;
    for (i = 0; i < DEPTH; i++)
    begin : g_cell
        localparam int UP = (i == DEPTH - 1) ? i : i + 1;

        assign ctl[i] = '{
            load:  acmd.append_en && (32'(count) == i),
            shift: acmd.remove_en && (32'(acmd.pos) <= i),
            sel:   acmd.sel_en && (32'(acmd.pos) == i)
        };

        ilcp_cell u_cell (
            .clk     (clk),
            .ctl     (ctl[i]),
            .word_in (acmd.word),
            .upper   (word[UP]),
            .word    (word[i]),
            .tap     (tap[i])
        );
    end

    ilcp_or_tree #(
        .LEAVES (DEPTH),
        .LEVELS (TREE_LVL)
    ) u_tree (
        .clk   (clk),
        .rst_n (rst_n),
        .leaf  (tap),
        .root  (root)
    );

    ilcp_ctrl #(
        .DEPTH    (DEPTH),
        .CNT_W    (CNT_W),
        .TREE_LVL (TREE_LVL)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .root         (root),
        .count        (count),
        .acmd         (acmd),
        .result_valid (result_valid),
        .result       (result)
    );

    `ILCP_ASSERT_NXT(a_accept_busy, start && !busy, busy, "accepted item did not raise busy")
    `ILCP_ASSERT_IMP(a_result_idle, result_valid, !busy, "result strobe while still busy")
    `ILCP_ASSERT_IMP(a_fault_zero, result_valid && result.fault, result.word_out == '0, "fault with nonzero word")
    `ILCP_ASSERT_IMP(a_count_max, 1'b1, 32'(count) <= DEPTH, "word count above store depth")

endmodule

// ----- bench/indexed_list_with_capacity_policy_tb.sv -----
// Testbench for the indexed list block: directed command table, then random commands checked
`timescale 1ns / 100ps
module indexed_list_with_capacity_policy_tb;
    import ilcp_pkg::*;

    localparam int DEPTH = 1024;
    localparam int IDLE_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 30;
    localparam logic [1:0] CMD_UNKNOWN = 2'd3;

    typedef struct {
        item_t cmd;
        bit    typed;
        res_t  want;
    } dir_row_t;

    typedef struct {
        logic [FIELD_W-1:0] init_cap;
        logic [4:0]         grow;
        logic [6:0]         thresh;
        logic [4:0]         shrink_div;
        int                 items;
        int                 append_pct_a;
        int                 append_pct_b;
    } phase_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    item_t                cmd_item = '0;
    logic                 result_valid;
    res_t                 result;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [FIELD_W-1:0]   cfg_data = '0;

    logic [WORD_W-1:0] list_words [DEPTH];
    int unsigned       list_count;
    int unsigned       list_cap;
    int unsigned       reg_init_cap;
    int unsigned       reg_grow;
    int unsigned       reg_thresh;
    int unsigned       reg_div;

    res_t pending_results [$];
    int   mismatch_count = 0;
    int   idle_cycles = 0;

    indexed_list_with_capacity_policy #(
        .DEPTH(DEPTH)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .item(cmd_item),
        .result_valid(result_valid),
        .result(result),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    function automatic int unsigned clamp_depth(int unsigned v);
        return (v > DEPTH) ? DEPTH : v;
    endfunction

    function automatic void apply_register(logic [CFG_IDX_W-1:0] idx, logic [FIELD_W-1:0] data);
        case (idx)
            CFG_INIT_CAP:
            begin
                reg_init_cap = data;
                list_count = 0;
                list_cap = clamp_depth(data);
            end
            CFG_GROW:   reg_grow = data[4:0];
            CFG_THRESH: reg_thresh = data[6:0];
            CFG_DIV:    reg_div = data[4:0];
            default:    ;
        endcase
    endfunction

    function automatic res_t execute_command(item_t c);
        res_t        r;
        int unsigned grown;
        int unsigned thr;
        int unsigned shrunk;
        int unsigned k;
        r = '0;
        case (c.command)
            CMD_APPEND:
            begin
                if (list_count >= DEPTH)
                begin
                    r.fault = 1'b1;
                end
                else
                begin
                    if (list_count >= list_cap)
                    begin
                        grown = list_cap * reg_grow;
                        if (grown == 0)
                            grown = 1;
                        grown = clamp_depth(grown);
                        if (grown <= list_count)
                            grown = list_count + 1;
                        list_cap = grown;
                    end
                    list_words[list_count] = c.word_in;
                    list_count++;
                end
            end
            CMD_REMOVE:
            begin
                if (c.position >= list_count)
                begin
                    r.fault = 1'b1;
                end
                else
                begin
                    r.word_out = list_words[c.position];
                    list_count--;
                    for (k = c.position; k < list_count; k++)
                        list_words[k] = list_words[k + 1];
                    if (reg_div != 0)
                    begin
                        thr = (reg_thresh < reg_div) ? 2 * reg_div : reg_thresh;
                        shrunk = list_cap / reg_div;
                        if (shrunk >= reg_init_cap && list_count * thr < list_cap)
                            list_cap = shrunk;
                    end
                end
            end
            CMD_READ:
            begin
                if (c.position >= list_count)
                    r.fault = 1'b1;
                else
                    r.word_out = list_words[c.position];
            end
            default: r.fault = 1'b1;
        endcase
        r.count_now = list_count[FIELD_W-1:0];
        r.capacity_now = list_cap[FIELD_W-1:0];
        return r;
    endfunction

    function automatic dir_row_t mk_row(logic [1:0] op, int pos, logic [WORD_W-1:0] w,
                                        bit typed, logic [WORD_W-1:0] wout, bit flt,
                                        int cnt, int cap);
        dir_row_t row;
        row.cmd.command = op;
        row.cmd.position = pos[POS_W-1:0];
        row.cmd.word_in = w;
        row.typed = typed;
        row.want.word_out = wout;
        row.want.fault = flt;
        row.want.count_now = cnt[FIELD_W-1:0];
        row.want.capacity_now = cap[FIELD_W-1:0];
        return row;
    endfunction

    function automatic logic [WORD_W-1:0] pick_word();
        if ($urandom_range(0, 9) != 0)
            return $urandom;
        case ($urandom_range(0, 3))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return '0;
            default: return '1;
        endcase
    endfunction

    function automatic item_t make_random_item(int append_pct);
        item_t c;
        int    r;
        c.command = CMD_APPEND;
        c.position = POS_W'($urandom_range(0, DEPTH - 1));
        c.word_in = pick_word();
        r = $urandom_range(0, 99);
        if (r < append_pct)
        begin
            c.command = CMD_APPEND;
        end
        else if (r < append_pct + 4)
        begin
            c.command = CMD_UNKNOWN;
        end
        else
        begin
            c.command = $urandom_range(0, 1) ? CMD_REMOVE : CMD_READ;
            if (list_count > 0 && $urandom_range(0, 9) != 0)
                c.position = POS_W'($urandom_range(0, list_count - 1));
            else if (list_count < DEPTH && $urandom_range(0, 1))
                c.position = POS_W'(list_count);
        end
        return c;
    endfunction

    function automatic int pick_gap(int n);
        int r;
        if ((n / 64) % 4 == 1)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(6, 40);
    endfunction

    task automatic report_mismatch(string field, logic [WORD_W-1:0] got,
                                   logic [WORD_W-1:0] want);
        $display("%0t: mismatch in %s: got %h, expected %h", $time, field, got, want);
        mismatch_count++;
    endtask

    task automatic send_command(item_t c, bit typed, res_t want, int gap);
        res_t predicted;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        cmd_item <= c;
        do @(posedge clk); while (busy);
        predicted = execute_command(c);
        pending_results.push_back(typed ? want : predicted);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [FIELD_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        apply_register(idx, data);
    endtask

    task automatic wait_idle();
        while (pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        res_t want;
        if (rst_n && result_valid)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch("unexpected result", result.word_out, '0);
            end
            else
            begin
                want = pending_results.pop_front();
                if (result.word_out !== want.word_out)
                    report_mismatch("word_out", result.word_out, want.word_out);
                if (result.fault !== want.fault)
                    report_mismatch("fault", 32'(result.fault), 32'(want.fault));
                if (result.count_now !== want.count_now)
                    report_mismatch("count_now", 32'(result.count_now), 32'(want.count_now));
                if (result.capacity_now !== want.capacity_now)
                    report_mismatch("capacity_now", 32'(result.capacity_now),
                                    32'(want.capacity_now));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || result_valid || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        dir_row_t rows [$];
        phase_t   phases [$];
        phase_t   ph;
        int       n;
        reg_init_cap = RST_INIT_CAP;
        reg_grow = RST_GROW;
        reg_thresh = RST_THRESH;
        reg_div = RST_DIV;
        list_count = 0;
        list_cap = clamp_depth(RST_INIT_CAP);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        rows.push_back(mk_row(CMD_READ,    0,    32'h0,         1, 32'h0, 1, 0, 10));
        rows.push_back(mk_row(CMD_REMOVE,  1023, 32'hFFFF_FFFF, 1, 32'h0, 1, 0, 10));
        rows.push_back(mk_row(CMD_UNKNOWN, 1023, 32'h7FFF_FFFF, 1, 32'h0, 1, 0, 10));
        rows.push_back(mk_row(CMD_APPEND,  1023, 32'h7FFF_FFFF, 1, 32'h0, 0, 1, 10));
        rows.push_back(mk_row(CMD_APPEND,  0,    32'h8000_0000, 1, 32'h0, 0, 2, 10));
        rows.push_back(mk_row(CMD_APPEND,  512,  32'hFFFF_FFFF, 1, 32'h0, 0, 3, 10));
        rows.push_back(mk_row(CMD_APPEND,  0,    32'h0,         1, 32'h0, 0, 4, 10));
        rows.push_back(mk_row(CMD_READ,    0,    32'h0,         1, 32'h7FFF_FFFF, 0, 4, 10));
        rows.push_back(mk_row(CMD_READ,    1,    32'hFFFF_FFFF, 1, 32'h8000_0000, 0, 4, 10));
        rows.push_back(mk_row(CMD_READ,    3,    32'h0,         0, 32'h0, 0, 0, 0));
        rows.push_back(mk_row(CMD_READ,    4,    32'h0,         1, 32'h0, 1, 4, 10));
        rows.push_back(mk_row(CMD_APPEND,  0,    32'h1234_5678, 0, 32'h0, 0, 0, 0));
        rows.push_back(mk_row(CMD_APPEND,  0,    32'hA5A5_A5A5, 0, 32'h0, 0, 0, 0));
        rows.push_back(mk_row(CMD_APPEND,  0,    32'h5A5A_5A5A, 0, 32'h0, 0, 0, 0));
        rows.push_back(mk_row(CMD_APPEND,  0,    32'h0000_0001, 0, 32'h0, 0, 0, 0));
        rows.push_back(mk_row(CMD_APPEND,  0,    32'hFFFF_FFFE, 0, 32'h0, 0, 0, 0));
        rows.push_back(mk_row(CMD_APPEND,  0,    32'h3C3C_C3C3, 0, 32'h0, 0, 0, 0));
        rows.push_back(mk_row(CMD_APPEND,  0,    32'h0F0F_0F0F, 1, 32'h0, 0, 11, 20));
        rows.push_back(mk_row(CMD_REMOVE,  0,    32'h0,         0, 32'h0, 0, 0, 0));
        rows.push_back(mk_row(CMD_REMOVE,  1023, 32'h0,         1, 32'h0, 1, 10, 20));
        rows.push_back(mk_row(CMD_READ,    9,    32'h0,         0, 32'h0, 0, 0, 0));
        rows.push_back(mk_row(CMD_REMOVE,  9,    32'h0,         0, 32'h0, 0, 0, 0));
        foreach (rows[i])
            send_command(rows[i].cmd, rows[i].typed, rows[i].want, pick_gap(i));

        phases.push_back('{11'd0,    5'd0,  7'd0,   5'd0,  60,   55, 45});
        phases.push_back('{11'd1,    5'd1,  7'd1,   5'd1,  60,   60, 40});
        phases.push_back('{11'd1,    5'd31, 7'd127, 5'd31, 1180, 93, 93});
        phases.push_back('{11'd2047, 5'd16, 7'd64,  5'd16, 60,   50, 50});
        phases.push_back('{11'd1024, 5'd0,  7'd2,   5'd5,  60,   55, 45});
        phases.push_back('{11'd2,    5'd3,  7'd2,   5'd2,  80,   75, 25});
        phases.push_back('{11'd4,    5'd4,  7'd1,   5'd3,  80,   75, 25});
        repeat (3)
        begin
            ph.init_cap = FIELD_W'($urandom_range(0, 40));
            ph.grow = 5'($urandom_range(0, 31));
            ph.thresh = 7'($urandom_range(0, 127));
            ph.shrink_div = 5'($urandom_range(0, 31));
            ph.items = 50;
            ph.append_pct_a = 65;
            ph.append_pct_b = 35;
            phases.push_back(ph);
        end

        foreach (phases[p])
        begin
            ph = phases[p];
            start <= 1'b0;
            wait_idle();
            write_register(CFG_GROW, FIELD_W'(ph.grow));
            write_register(CFG_THRESH, FIELD_W'(ph.thresh));
            write_register(CFG_DIV, FIELD_W'(ph.shrink_div));
            write_register(CFG_INIT_CAP, ph.init_cap);
            write_register(CFG_IDX_W'(4 + p % 4), FIELD_W'($urandom_range(0, 2047)));
            cfg_valid <= 1'b0;
            for (n = 0; n < ph.items; n++)
                send_command(make_random_item(n < ph.items / 2 ? ph.append_pct_a
                                                                : ph.append_pct_b),
                             1'b0, '0, pick_gap(n));
        end

        start <= 1'b0;
        wait_idle();
        if (mismatch_count == 0 && pending_results.size() == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
